// File: src/sqvs_pkg.sv
// Shared types, constants and tables for the sprite quad vertex setup block.
// Holds the request, vertex and job structs, the octant trig ROM builder
// and the texcoord permutation. No dependencies.
package sqvs_pkg;

  localparam int COORD_BITS     = 12;
  localparam int ANGLE_BITS     = 12;
  localparam int TRIG_FRAC_BITS = 14;

  localparam int ANCHOR_W  = 16;
  localparam int SCALE_W   = 12;
  localparam int TEX_W     = COORD_BITS + 1;
  localparam int POS_W     = 24;
  localparam int POS256_W  = ANCHOR_W + 4;
  localparam int DIFF_W    = COORD_BITS + 1;
  localparam int DELTA_W   = DIFF_W + SCALE_W + 2;
  localparam int TRIG_W    = TRIG_FRAC_BITS + 1;
  localparam int STRIG_W   = TRIG_W + 1;
  localparam int PROD_W    = DELTA_W + STRIG_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int OCT_STEPS = 1 << (ANGLE_BITS - 3);
  localparam int OCT_IDX_W = $clog2(OCT_STEPS + 1);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(256);

  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BR = 2'd2,
    CORNER_BL = 2'd3
  } corner_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]      atlas_x;
    logic [COORD_BITS-1:0]      atlas_y;
    logic [COORD_BITS-1:0]      sprite_width;
    logic [COORD_BITS-1:0]      sprite_height;
    logic [COORD_BITS-1:0]      trim_offset_x;
    logic [COORD_BITS-1:0]      trim_offset_y;
    logic [COORD_BITS-1:0]      pivot_x;
    logic [COORD_BITS-1:0]      pivot_y;
    logic signed [ANCHOR_W-1:0] anchor_x;
    logic signed [ANCHOR_W-1:0] anchor_y;
    logic [ANGLE_BITS-1:0]      angle;
    logic [1:0]                 uv_rotation;
  } req_t;

  typedef struct packed {
    logic [1:0]              corner;
    logic signed [POS_W-1:0] vertex_x;
    logic signed [POS_W-1:0] vertex_y;
    logic [TEX_W-1:0]        tex_u;
    logic [TEX_W-1:0]        tex_v;
    logic                    last_corner;
  } vtx_t;

  // One classified request as it waits for the back end
  typedef struct packed {
    logic signed [DELTA_W-1:0]  dx0;
    logic signed [DELTA_W-1:0]  dx1;
    logic signed [DELTA_W-1:0]  dy0;
    logic signed [DELTA_W-1:0]  dy1;
    logic signed [STRIG_W-1:0]  sn;
    logic signed [STRIG_W-1:0]  cs;
    logic signed [POS256_W-1:0] anx;
    logic signed [POS256_W-1:0] any;
    logic [TEX_W-1:0]           u0;
    logic [TEX_W-1:0]           u1;
    logic [TEX_W-1:0]           v0;
    logic [TEX_W-1:0]           v1;
    logic [1:0]                 rot;
  } job_t;

  typedef logic [2*TRIG_W-1:0] trig_rom_t [0:OCT_STEPS];

  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    return p[123:60];
  endfunction

  // Unsigned quotient by shift and subtract, evaluated once while the ROM is built
  function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q, rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], n[i]};
      if (rem >= d) begin
        rem  = rem - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Build {sin, cos} for every step of the first octant from a Taylor series
  function automatic trig_rom_t build_trig_rom();
    trig_rom_t  rom;
    logic [63:0] two_pi, x, x2, ts, ss, tc, sc, tt, kk, rs, rc;
    two_pi = 64'h6487ED5110B4611A;
    for (int t = 0; t <= OCT_STEPS; t++) begin
      tt = 64'(t);
      x  = (two_pi >> ANGLE_BITS) * tt
         + (((two_pi & ((64'd1 << ANGLE_BITS) - 64'd1)) * tt) >> ANGLE_BITS);
      x2 = mul_q60(x, x);
      ts = x;
      ss = x;
      tc = 64'd1 << 60;
      sc = 64'd1 << 60;
      for (int k = 1; k <= 12; k++) begin
        kk = 64'(k);
        ts = div_u64(mul_q60(ts, x2), (64'd2 * kk) * (64'd2 * kk + 64'd1));
        tc = div_u64(mul_q60(tc, x2), (64'd2 * kk - 64'd1) * (64'd2 * kk));
        if (k[0]) begin
          ss = ss - ts;
          sc = sc - tc;
        end else begin
          ss = ss + ts;
          sc = sc + tc;
        end
      end
      rs = (ss + (64'd1 << (59 - TRIG_FRAC_BITS))) >> (60 - TRIG_FRAC_BITS);
      rc = (sc + (64'd1 << (59 - TRIG_FRAC_BITS))) >> (60 - TRIG_FRAC_BITS);
      rom[t] = {rs[TRIG_W-1:0], rc[TRIG_W-1:0]};
    end
    return rom;
  endfunction

  // Texcoord select per rotation and corner: bit 1 picks u1, bit 0 picks v1
  function automatic logic [1:0] uv_sel(input logic [1:0] rot, input logic [1:0] k);
    logic [7:0] row;
    unique case (rot)
      2'd0:    row = {2'd1, 2'd3, 2'd2, 2'd0};
      2'd1:    row = {2'd3, 2'd2, 2'd0, 2'd1};
      2'd2:    row = {2'd0, 2'd1, 2'd3, 2'd2};
      default: row = {2'd2, 2'd0, 2'd1, 2'd3};
    endcase
    return row[2*k +: 2];
  endfunction

endpackage

// File: src/sqvs_front.sv
// Front end: accepts requests, scales offsets, looks up the trig ROM and
// classifies the angle into quadrant values. Depends on sqvs_pkg.
module sqvs_front import sqvs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [SCALE_W-1:0] scale,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_t               req,
  output logic               job_valid,
  input  logic               job_full,
  output job_t               job
);

  localparam trig_rom_t TRIG_ROM = build_trig_rom();
  localparam int QUARTER = 1 << (ANGLE_BITS - 2);

  logic                       s1_valid;
  logic                       s1_load;
  logic signed [POS256_W-1:0] anx, any;
  logic signed [DELTA_W-1:0]  offx, offy;
  logic [DELTA_W-1:0]         wsc, hsc;
  logic [TEX_W-1:0]           u0, u1, v0, v1;
  logic [1:0]                 rot, quad;
  logic                       swap;
  logic [2*TRIG_W-1:0]        rom_q;

  logic [ANGLE_BITS-3:0]      r;
  logic [OCT_IDX_W-1:0]       idx;
  logic                       swap_next;
  logic signed [DIFF_W-1:0]   dtx, dty;
  logic signed [SCALE_W:0]    sc_s;
  logic signed [STRIG_W-1:0]  so, co;

  assign req_stall = s1_valid && job_full;
  assign s1_load   = req_valid && !req_stall;
  assign job_valid = s1_valid;

  // Fold the angle into the first octant
  always_comb begin
    r         = req.angle[ANGLE_BITS-3:0];
    swap_next = ({1'b0, r} > (ANGLE_BITS-1)'(QUARTER / 2));
    if (swap_next) begin
      idx = OCT_IDX_W'((ANGLE_BITS-1)'(QUARTER) - {1'b0, r});
    end else begin
      idx = OCT_IDX_W'(r);
    end
    dtx  = $signed({1'b0, req.trim_offset_x}) - $signed({1'b0, req.pivot_x});
    dty  = $signed({1'b0, req.trim_offset_y}) - $signed({1'b0, req.pivot_y});
    sc_s = $signed({1'b0, scale});
  end

  // Hold the stage valid until the queue takes the job
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (!job_full) begin
      s1_valid <= 1'b0;
    end
  end

  // Register scaled offsets and the ROM word
  always_ff @(posedge clk) begin
    if (s1_load) begin
      anx   <= POS256_W'(req.anchor_x) <<< 4;
      any   <= POS256_W'(req.anchor_y) <<< 4;
      offx  <= DELTA_W'(dtx) * DELTA_W'(sc_s);
      offy  <= DELTA_W'(dty) * DELTA_W'(sc_s);
      wsc   <= DELTA_W'(req.sprite_width) * DELTA_W'(scale);
      hsc   <= DELTA_W'(req.sprite_height) * DELTA_W'(scale);
      u0    <= TEX_W'(req.atlas_x);
      u1    <= TEX_W'(req.atlas_x) + TEX_W'(req.sprite_width);
      v0    <= TEX_W'(req.atlas_y);
      v1    <= TEX_W'(req.atlas_y) + TEX_W'(req.sprite_height);
      rot   <= req.uv_rotation;
      quad  <= req.angle[ANGLE_BITS-1:ANGLE_BITS-2];
      swap  <= swap_next;
      rom_q <= TRIG_ROM[idx];
    end
  end

  // Unfold octant and quadrant into signed sine and cosine
  always_comb begin
    if (swap) begin
      so = $signed({1'b0, rom_q[TRIG_W-1:0]});
      co = $signed({1'b0, rom_q[2*TRIG_W-1:TRIG_W]});
    end else begin
      so = $signed({1'b0, rom_q[2*TRIG_W-1:TRIG_W]});
      co = $signed({1'b0, rom_q[TRIG_W-1:0]});
    end
    job.dx0 = offx;
    job.dx1 = offx + $signed(wsc);
    job.dy0 = offy;
    job.dy1 = offy + $signed(hsc);
    job.anx = anx;
    job.any = any;
    job.u0  = u0;
    job.u1  = u1;
    job.v0  = v0;
    job.v1  = v1;
    job.rot = rot;
    unique case (quad)
      2'd0:    begin job.sn = so;  job.cs = co;  end
      2'd1:    begin job.sn = co;  job.cs = -so; end
      2'd2:    begin job.sn = -so; job.cs = -co; end
      default: begin job.sn = -co; job.cs = so;  end
    endcase
  end

endmodule

// File: src/sqvs_queue.sv
// Short job queue between the front and back ends.
// Depends on sqvs_pkg for the job type and depth.
module sqvs_queue import sqvs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t             mem [0:QUEUE_DEPTH-1];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push, do_pop;

  assign full    = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign head    = mem[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end
  end

  // Store the incoming job
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

endmodule

// File: src/sqvs_back.sv
// Back end: walks the four corners of each job, rotates, rounds and
// saturates, and holds the vertex for transfer. Depends on sqvs_pkg.
module sqvs_back import sqvs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  input  job_t job,
  output logic job_pop,
  output logic vtx_valid,
  input  logic vtx_stall,
  output vtx_t vtx
);

  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (TRIG_FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] VMAX = SUM_W'((1 << (POS_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] VMIN = -(SUM_W'(1) <<< (POS_W - 1));

  logic [1:0] k;
  logic       m_valid, m_en, o_en, take;

  logic signed [PROD_W-1:0]   p_xc, p_ys, p_xs, p_yc;
  logic signed [POS256_W-1:0] m_anx, m_any;
  logic [1:0]                 m_corner;
  logic [TEX_W-1:0]           m_u, m_v;

  logic signed [DELTA_W-1:0]  cx, cy;
  logic [1:0]                 sel;
  logic signed [SUM_W-1:0]    rx, ry, qx, qy;

  assign o_en    = !vtx_valid || !vtx_stall;
  assign m_en    = !m_valid || o_en;
  assign take    = job_valid && m_en;
  assign job_pop = take && (k == CORNER_BL);

  // Pick the corner deltas and texcoords
  always_comb begin
    cx  = (k == CORNER_TR || k == CORNER_BR) ? job.dx1 : job.dx0;
    cy  = (k == CORNER_BR || k == CORNER_BL) ? job.dy1 : job.dy0;
    sel = uv_sel(job.rot, k);
  end

  // Advance the corner counter
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= CORNER_TL;
    end else if (take) begin
      k <= k + 2'd1;
    end
  end

  // Multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (m_en) begin
      m_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      p_xc     <= PROD_W'(cx) * PROD_W'(job.cs);
      p_ys     <= PROD_W'(cy) * PROD_W'(job.sn);
      p_xs     <= PROD_W'(cx) * PROD_W'(job.sn);
      p_yc     <= PROD_W'(cy) * PROD_W'(job.cs);
      m_anx    <= job.anx;
      m_any    <= job.any;
      m_corner <= k;
      m_u      <= sel[1] ? job.u1 : job.u0;
      m_v      <= sel[0] ? job.v1 : job.v0;
    end
  end

  // Rotate about the anchor, round to 1/16 px
  always_comb begin
    rx = SUM_W'(m_anx) + ((SUM_W'(p_xc) - SUM_W'(p_ys) + HALF) >>> TRIG_FRAC_BITS);
    ry = SUM_W'(m_any) + ((SUM_W'(p_xs) + SUM_W'(p_yc) + HALF) >>> TRIG_FRAC_BITS);
    qx = (rx + SUM_W'(8)) >>> 4;
    qy = (ry + SUM_W'(8)) >>> 4;
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      vtx_valid <= 1'b0;
    end else if (o_en) begin
      vtx_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_en && m_valid) begin
      vtx.corner      <= m_corner;
      vtx.vertex_x    <= (qx > VMAX) ? POS_W'(VMAX) : ((qx < VMIN) ? POS_W'(VMIN) : POS_W'(qx));
      vtx.vertex_y    <= (qy > VMAX) ? POS_W'(VMAX) : ((qy < VMIN) ? POS_W'(VMIN) : POS_W'(qy));
      vtx.tex_u       <= m_u;
      vtx.tex_v       <= m_v;
      vtx.last_corner <= (m_corner == CORNER_BL);
    end
  end

endmodule

// File: src/sprite_quad_vertex_setup_core.sv
// Sprite quad vertex setup: four rotated corner vertices per request.
// The front end registers each request and the job queue holds it while the
// back end walks the corners of earlier jobs through its multiply and output
// registers, one vertex per cycle unless the output stalls. Synchronous reset
// empties the pipeline and queue and sets the scale register to 1.0 (256).
module sprite_quad_vertex_setup_core import sqvs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               scale_we,
  input  logic [SCALE_W-1:0] scale_wdata,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_t               req,
  output logic               vtx_valid,
  input  logic               vtx_stall,
  output vtx_t               vtx
);

  logic [SCALE_W-1:0] scale;
  logic               f_valid, q_full, q_valid, q_pop;
  job_t               f_job, q_head;

  // Scale register
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (scale_we) begin
      scale <= scale_wdata;
    end
  end

  sqvs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .scale     (scale),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .job_valid (f_valid),
    .job_full  (q_full),
    .job       (f_job)
  );

  sqvs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (f_valid),
    .push_job (f_job),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  sqvs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job       (q_head),
    .job_pop   (q_pop),
    .vtx_valid (vtx_valid),
    .vtx_stall (vtx_stall),
    .vtx       (vtx)
  );

endmodule

// File: tb/sv/tb_top.sv
// Testbench for the sprite quad vertex setup core: predicts the four corner
// vertices of every request and checks each vertex transfer against them.
// Depends on sqvs_pkg and sprite_quad_vertex_setup_core.
module tb_top;
  import sqvs_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic scale_we = 1'b0;
  logic [SCALE_W-1:0] scale_wdata = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic vtx_valid;
  logic vtx_stall = 1'b0;
  vtx_t vtx;

  // Predictor copy of the scale register
  logic [SCALE_W-1:0] scale_q;
  vtx_t pending_vtx[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit stall_hold = 1'b0;
  localparam int WATCHDOG_LIMIT = 20000;

  sprite_quad_vertex_setup_core DUT (
    .clk(clk), .rst(rst), .scale_we(scale_we), .scale_wdata(scale_wdata),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .vtx_valid(vtx_valid), .vtx_stall(vtx_stall), .vtx(vtx)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Q60 product, upper bits
  function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    return p[123:60];
  endfunction

  // Sine and cosine of t steps within the first octant, by series
  function automatic void octant_sin_cos(input longint t, output longint sn,
                                         output longint cs);
    logic [63:0] x, x2, ts, ss, tc, sc;
    longint d;
    x = (64'h6487ED5110B4611A >> ANGLE_BITS) * 64'(t)
      + (((64'h6487ED5110B4611A & ((64'd1 << ANGLE_BITS) - 1)) * 64'(t)) >> ANGLE_BITS);
    x2 = q60_mul(x, x);
    ts = x; ss = x; tc = 64'd1 << 60; sc = 64'd1 << 60;
    for (int k = 1; k <= 12; k++) begin
      d = 2 * k;
      ts = q60_mul(ts, x2) / 64'(d * (d + 1));
      tc = q60_mul(tc, x2) / 64'(d * (d - 1));
      if (k % 2 == 1) begin
        ss -= ts; sc -= tc;
      end else begin
        ss += ts; sc += tc;
      end
    end
    sn = longint'((ss + (64'd1 << (59 - TRIG_FRAC_BITS))) >> (60 - TRIG_FRAC_BITS));
    cs = longint'((sc + (64'd1 << (59 - TRIG_FRAC_BITS))) >> (60 - TRIG_FRAC_BITS));
  endfunction

  function automatic void angle_sin_cos(input logic [ANGLE_BITS-1:0] a, output longint sn,
                                        output longint cs);
    longint quarter, r, so, co;
    quarter = 1 << (ANGLE_BITS - 2);
    r = a & (quarter - 1);
    if (r <= quarter / 2) octant_sin_cos(r, so, co);
    else octant_sin_cos(quarter - r, co, so);
    case (a >> (ANGLE_BITS - 2))
      0: begin sn = so; cs = co; end
      1: begin sn = co; cs = -so; end
      2: begin sn = -so; cs = -co; end
      default: begin sn = -co; cs = so; end
    endcase
  endfunction

  function automatic longint floor_div(input longint v, input int n);
    return v >>> n;
  endfunction

  function automatic longint clamp24(input longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // Work out the four corners of one request and queue them
  task automatic predict_quad(input req_t r);
    longint sn, cs, sc, anx, any, x0, y0, x1, y1, cx, cy, dx, dy, rx, ry;
    logic [TEX_W-1:0] us[2], vs[2];
    logic [1:0] sel;
    vtx_t v;
    sc = scale_q;
    angle_sin_cos(r.angle, sn, cs);
    anx = longint'(r.anchor_x) * 16;
    any = longint'(r.anchor_y) * 16;
    x0 = anx + (longint'(r.trim_offset_x) - longint'(r.pivot_x)) * sc;
    y0 = any + (longint'(r.trim_offset_y) - longint'(r.pivot_y)) * sc;
    x1 = x0 + longint'(r.sprite_width) * sc;
    y1 = y0 + longint'(r.sprite_height) * sc;
    us[0] = r.atlas_x; us[1] = r.atlas_x + r.sprite_width;
    vs[0] = r.atlas_y; vs[1] = r.atlas_y + r.sprite_height;
    for (int k = 0; k < 4; k++) begin
      cx = (k == 1 || k == 2) ? x1 : x0;
      cy = (k >= 2) ? y1 : y0;
      dx = cx - anx;
      dy = cy - any;
      rx = anx + floor_div(dx * cs - dy * sn + (1 << (TRIG_FRAC_BITS - 1)), TRIG_FRAC_BITS);
      ry = any + floor_div(dx * sn + dy * cs + (1 << (TRIG_FRAC_BITS - 1)), TRIG_FRAC_BITS);
      case (r.uv_rotation)
        2'd0: sel = (k == 0) ? 2'd0 : (k == 1) ? 2'd2 : (k == 2) ? 2'd3 : 2'd1;
        2'd1: sel = (k == 0) ? 2'd1 : (k == 1) ? 2'd0 : (k == 2) ? 2'd2 : 2'd3;
        2'd2: sel = (k == 0) ? 2'd2 : (k == 1) ? 2'd3 : (k == 2) ? 2'd1 : 2'd0;
        default: sel = (k == 0) ? 2'd3 : (k == 1) ? 2'd1 : (k == 2) ? 2'd0 : 2'd2;
      endcase
      v.corner = 2'(k);
      v.vertex_x = POS_W'(clamp24(floor_div(rx + 8, 4)));
      v.vertex_y = POS_W'(clamp24(floor_div(ry + 8, 4)));
      v.tex_u = us[sel[1]];
      v.tex_v = vs[sel[0]];
      v.last_corner = (k == 3);
      pending_vtx.push_back(v);
    end
  endtask

  // Mostly short gaps, a few long ones, often none
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver: check each vertex transfer
  always @(posedge clk) begin
    if (!rst && vtx_valid && !vtx_stall) begin
      if (pending_vtx.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected vertex %p", vtx);
      end else begin
        if (vtx !== pending_vtx[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("vertex mismatch: expected %p actual %p", pending_vtx[0], vtx);
        end
        void'(pending_vtx.pop_front());
      end
    end
  end

  // Hold stall for random-length runs
  always @(negedge clk) begin
    if (stall_hold) begin
      vtx_stall <= 1'b1;
    end else if (stall_left > 0) begin
      vtx_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      stall_left = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      vtx_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left = stall_left - 1;
    end
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (vtx_valid && !vtx_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Send one request and hold it until the transfer
  task automatic send_request(input req_t r);
    int g;
    g = gap_len();
    if (g > 0) begin
      req_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    predict_quad(r);
    @(negedge clk);
  endtask

  // Drain results, let the pipe settle, then write the scale
  task automatic write_scale(input logic [SCALE_W-1:0] val);
    req_valid <= 1'b0;
    while (pending_vtx.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
    scale_we <= 1'b1;
    scale_wdata <= val;
    @(negedge clk);
    scale_we <= 1'b0;
    scale_q = val;
  endtask

  function automatic req_t random_request();
    req_t r;
    r = req_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    // Bias angles toward quadrant and octant boundaries now and then
    if ($urandom_range(0, 3) == 0)
      r.angle = ANGLE_BITS'($urandom_range(0, 7) * 512 + $urandom_range(0, 2) - 1);
    return r;
  endfunction

  task automatic test_directed();
    req_t r;
    logic [ANGLE_BITS-1:0] angles[6];
    // Plain sprite at unit scale, every texcoord rotation
    for (int rot = 0; rot < 4; rot++) begin
      r = '0;
      r.atlas_x = 12'd100; r.atlas_y = 12'd200; r.sprite_width = 12'd32;
      r.sprite_height = 12'd16; r.pivot_x = 12'd16; r.pivot_y = 12'd8;
      r.anchor_x = 16'sd1600; r.anchor_y = -16'sd800;
      r.uv_rotation = 2'(rot);
      r.angle = ANGLE_BITS'(rot * 1024);
      send_request(r);
    end
    // Field extremes: all zero, all ones, texcoord wrap
    send_request('0);
    send_request('1);
    r = '1; r.anchor_x = 16'sh7FFF; r.anchor_y = -16'sh8000; r.pivot_x = '0; r.pivot_y = '0;
    send_request(r);
    r = '0; r.anchor_x = -16'sh8000; r.anchor_y = 16'sh7FFF; r.pivot_x = '1; r.pivot_y = '1;
    send_request(r);
    // Octant boundaries and near-boundary angles
    angles = '{12'd512, 12'd511, 12'd513, 12'd1536, 12'd4095, 12'd1};
    foreach (angles[i]) begin
      r = random_request();
      r.angle = angles[i];
      send_request(r);
    end
  endtask

  task automatic test_scale_extremes();
    req_t r;
    // Zero scale collapses every corner onto the anchor
    write_scale('0);
    repeat (4) send_request(random_request());
    // Largest scale gives the widest corner offsets
    write_scale('1);
    for (int i = 0; i < 6; i++) begin
      r = random_request();
      r.trim_offset_x = (i % 2) ? '1 : '0;
      r.pivot_x = (i % 2) ? '0 : '1;
      send_request(r);
    end
  endtask

  task automatic test_random();
    logic [SCALE_W-1:0] scales[5];
    scales = '{12'd256, 12'd1, 12'd4095, 12'($urandom), 12'd128};
    for (int ph = 0; ph < 5; ph++) begin
      write_scale(scales[ph]);
      repeat (80) send_request(random_request());
    end
  endtask

  task automatic test_backpressure();
    // Long receiver hold while requests keep coming
    stall_hold = 1'b1;
    fork
      repeat (6) send_request(random_request());
      begin repeat (40) @(negedge clk); stall_hold = 1'b0; end
    join
  endtask

  initial begin
    scale_q = SCALE_RESET;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_scale_extremes();
    test_backpressure();
    test_random();
    req_valid <= 1'b0;
    while (pending_vtx.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_vtx.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// File: sim.f
src/sqvs_pkg.sv
src/sqvs_front.sv
src/sqvs_queue.sv
src/sqvs_back.sv
src/sprite_quad_vertex_setup_core.sv
tb/sv/tb_top.sv
